FILE: sv/bsc_pkg.sv
package bsc_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CsrIndexWidth = 3;

   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam csr_index_type CSR_MODE         = 3'd0;
   localparam csr_index_type CSR_START_VALUE  = 3'd1;
   localparam csr_index_type CSR_ESCAPE_VALUE = 3'd2;
   localparam csr_index_type CSR_START_CODE   = 3'd3;
   localparam csr_index_type CSR_ESCAPE_CODE  = 3'd4;

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type             mode;
      logic [ByteWidth-1:0] start_value;
      logic [ByteWidth-1:0] escape_value;
      logic [ByteWidth-1:0] start_code;
      logic [ByteWidth-1:0] escape_code;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           count;
      logic [ByteWidth-1:0] first;
      logic [ByteWidth-1:0] second;
      logic                 pending;
   } step_type;

   typedef struct packed {
      logic                 pair;
      logic [ByteWidth-1:0] first;
      logic [ByteWidth-1:0] second;
      logic                 last;
   } entry_type;

endpackage

FILE: sv/bsc_step.sv
module bsc_step
   import bsc_pkg::*;
(
   input  logic [ByteWidth-1:0] in_byte,
   input  logic                 in_last,
   input  logic                 pending,
   input  cfg_type              cfg,
   output step_type             step
);

   always_comb begin
      step.count   = 2'd1;
      step.first   = in_byte;
      step.second  = in_byte;
      step.pending = 1'b0;
      if (cfg.mode == MODE_ENCODE) begin
         if (in_byte == cfg.start_value) begin
            step.count  = 2'd2;
            step.first  = cfg.escape_value;
            step.second = cfg.start_code;
         end else if (in_byte == cfg.escape_value) begin
            step.count  = 2'd2;
            step.first  = cfg.escape_value;
            step.second = cfg.escape_code;
         end
      end else if (pending) begin
         if (in_byte == cfg.start_code) begin
            step.first = cfg.start_value;
         end else if (in_byte == cfg.escape_code) begin
            step.first = cfg.escape_value;
         end else if (in_byte == cfg.escape_value) begin
            step.first  = cfg.escape_value;
            step.second = cfg.escape_value;
            if (in_last) begin
               step.count = 2'd2;
            end else begin
               step.pending = 1'b1;
            end
         end else begin
            step.count = 2'd2;
            step.first = cfg.escape_value;
         end
      end else if (in_byte == cfg.escape_value && !in_last) begin
         step.count   = 2'd0;
         step.pending = 1'b1;
      end
   end

endmodule

FILE: sv/byte_stuffing_codec.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_in_byte, req_in_last
// rsp      out        rsp_valid/rsp_stall  rsp_out_byte, rsp_out_item_end, rsp_out_payload_end
// csr      in         csr_we               csr_index, csr_wdata
//
// One word per cycle on req while req_stall is low; a word that leaves a stuffed pair yields two rsp bytes.
// A word passes through the input register, then the two-entry result queue.
// The step unit between the input register and the queue sets how many bytes each word yields.
// Reset clears the input valid flag, queue pointers, count, half and escape flags, and sets the config to defaults.
// req_stall rises only when the input register holds a word and the queue is full.
module byte_stuffing_codec
   import bsc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ByteWidth-1:0]     req_in_byte,
   input  logic                     req_in_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ByteWidth-1:0]     rsp_out_byte,
   output logic                     rsp_out_item_end,
   output logic                     rsp_out_payload_end,
   input  logic                     csr_we,
   input  csr_index_type            csr_index,
   input  logic [ByteWidth-1:0]     csr_wdata
);

   cfg_type              cfg_ff;
   logic                 s1_valid_ff, s1_valid_in;
   logic [ByteWidth-1:0] s1_byte_ff;
   logic                 s1_last_ff;
   logic                 pending_ff, pending_in;
   entry_type            queue_ff [2];
   logic                 wr_ptr_ff, rd_ptr_ff, half_ff;
   logic [1:0]           count_ff, count_in;
   step_type             step;
   logic                 load, move, push, pop_entry, rsp_take;
   entry_type            head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= MODE_ENCODE;
         cfg_ff.start_value  <= 8'd126;
         cfg_ff.escape_value <= 8'd125;
         cfg_ff.start_code   <= 8'd94;
         cfg_ff.escape_code  <= 8'd93;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:         cfg_ff.mode         <= mode_type'(csr_wdata[0]);
            CSR_START_VALUE:  cfg_ff.start_value  <= csr_wdata;
            CSR_ESCAPE_VALUE: cfg_ff.escape_value <= csr_wdata;
            CSR_START_CODE:   cfg_ff.start_code   <= csr_wdata;
            CSR_ESCAPE_CODE:  cfg_ff.escape_code  <= csr_wdata;
            default: ;
         endcase
      end
   end

   bsc_step u_step (
      .in_byte (s1_byte_ff),
      .in_last (s1_last_ff),
      .pending (pending_ff),
      .cfg     (cfg_ff),
      .step    (step)
   );

   assign move      = s1_valid_ff && (step.count == 2'd0 || count_ff != 2'd2);
   assign push      = move && step.count != 2'd0;
   assign req_stall = s1_valid_ff && !move;
   assign load      = req_valid && !req_stall;
   assign s1_valid_in = load || (s1_valid_ff && !move);
   assign pending_in  = move ? step.pending : pending_ff;

   assign head                = queue_ff[rd_ptr_ff];
   assign rsp_valid           = count_ff != 2'd0;
   assign rsp_out_byte        = half_ff ? head.second : head.first;
   assign rsp_out_item_end    = half_ff || !head.pair;
   assign rsp_out_payload_end = rsp_out_item_end && head.last;
   assign rsp_take            = rsp_valid && !rsp_stall;
   assign pop_entry           = rsp_take && rsp_out_item_end;
   assign count_in            = count_ff + {1'b0, push} - {1'b0, pop_entry};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pending_ff  <= 1'b0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         half_ff     <= 1'b0;
         count_ff    <= 2'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pending_ff  <= pending_in;
         count_ff    <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_entry) begin
            rd_ptr_ff <= !rd_ptr_ff;
            half_ff   <= 1'b0;
         end else if (rsp_take) begin
            half_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_byte_ff <= req_in_byte;
         s1_last_ff <= req_in_last;
      end
      if (push) begin
         queue_ff[wr_ptr_ff].pair   <= step.count == 2'd2;
         queue_ff[wr_ptr_ff].first  <= step.first;
         queue_ff[wr_ptr_ff].second <= step.second;
         queue_ff[wr_ptr_ff].last   <= s1_last_ff;
      end
   end

endmodule
